// ===== hdl/wre_pkg.sv =====
package wre_pkg;

  localparam int unsigned MaxOpenDef     = 8;
  localparam int unsigned MaxWindowDef   = 4096;
  localparam int unsigned MaxChannelsDef = 8;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  localparam logic [CfgIdxW-1:0] RegWindowFrames = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHopFrames    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegChannelCount = 3'd2;
  localparam logic [CfgIdxW-1:0] RegNoiseFloor   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegEnvScale     = 3'd4;

  localparam logic [12:0] WindowReset = 13'd480;
  localparam logic [12:0] HopReset    = 13'd240;
  localparam logic [3:0]  ChReset     = 4'd1;
  localparam logic [15:0] ScaleReset  = 16'd256;
  localparam logic [15:0] EnvMax      = 16'd32768;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_CHECK
  } top_state_e;

  typedef enum logic [2:0] {
    EU_IDLE,
    EU_COUNT,
    EU_DIV,
    EU_SQRT,
    EU_MUL,
    EU_CLAMP,
    EU_DONE
  } env_state_e;

  // Control broadcast from the sequencer to every window cell.
  typedef struct packed {
    logic clear;
    logic shift;
    logic add;
  } cell_ctl_t;

endpackage

// ===== hdl/wre_cell.sv =====
module wre_cell import wre_pkg::*; #(
  parameter int unsigned SumW = 48,
  parameter int unsigned FrW  = 13,
  parameter int unsigned FsW  = 35
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctl_t       ctl_i,
  input  logic            open_i,
  input  logic [FsW-1:0]  frame_sum_i,
  input  logic            nb_valid_i,
  input  logic [SumW-1:0] nb_sum_i,
  input  logic [FrW-1:0]  nb_frames_i,
  output logic            valid_o,
  output logic [SumW-1:0] sum_o,
  output logic [FrW-1:0]  frames_o
);

  logic            valid_q;
  logic [SumW-1:0] sum_q, sum_d;
  logic [FrW-1:0]  frames_q, frames_d;

  always_comb begin
    sum_d    = sum_q;
    frames_d = frames_q;
    if (ctl_i.shift) begin
      sum_d    = nb_sum_i;
      frames_d = nb_frames_i;
    end else if (ctl_i.add && (valid_q || open_i)) begin
      // A window opening on this frame starts from an empty sum.
      sum_d    = (open_i ? '0 : sum_q) + SumW'(frame_sum_i);
      frames_d = (open_i ? '0 : frames_q) + FrW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctl_i.clear) begin
      valid_q <= 1'b0;
    end else if (ctl_i.shift) begin
      valid_q <= nb_valid_i;
    end else if (ctl_i.add && open_i) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q    <= sum_d;
    frames_q <= frames_d;
  end

  assign valid_o  = valid_q;
  assign sum_o    = sum_q;
  assign frames_o = frames_q;

endmodule

// ===== hdl/wre_env.sv =====
module wre_env import wre_pkg::*; #(
  parameter int unsigned SumW = 48,
  parameter int unsigned FrW  = 13,
  parameter int unsigned ChW  = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] sum_i,
  input  logic [FrW-1:0]  frames_i,
  input  logic [ChW-1:0]  ch_i,
  input  logic            last_i,
  input  logic [15:0]     noise_floor_i,
  input  logic [15:0]     env_scale_i,
  output logic            ready_o,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output logic [15:0]     res_env_o,
  output logic            res_last_o
);

  localparam int unsigned CntW = FrW + ChW;
  localparam int unsigned ItW  = $clog2(SumW + 1);

  env_state_e state_q, state_d;

  logic [SumW-1:0] quo_q, quo_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [FrW-1:0]  fr_q, fr_d;
  logic [ChW-1:0]  ch_q, ch_d;
  logic [ItW-1:0]  it_q, it_d;
  logic [31:0]     v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic [31:0]     prod_q, prod_d;
  logic [15:0]     env_q, env_d;
  logic            last_q, last_d;

  logic [CntW:0]   rem_sh;
  logic [31:0]     trial;
  logic [15:0]     rms;
  logic [23:0]     shifted;

  always_comb begin
    rem_sh  = {rem_q, quo_q[SumW-1]};
    trial   = res_q + bit_q;
    rms     = res_q[15:0];
    shifted = prod_q[31:8];
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      EU_IDLE:  if (start_i) state_d = EU_COUNT;
      EU_COUNT: state_d = EU_DIV;
      EU_DIV:   if (it_q == ItW'(1)) state_d = EU_SQRT;
      EU_SQRT:  if (bit_q[1:0] != 2'b00) state_d = EU_MUL;
      EU_MUL:   state_d = EU_CLAMP;
      EU_CLAMP: state_d = EU_DONE;
      EU_DONE:  if (res_ready_i) state_d = EU_IDLE;
      default:  state_d = EU_IDLE;
    endcase
  end

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    fr_d   = fr_q;
    ch_d   = ch_q;
    it_d   = it_q;
    v_d    = v_q;
    res_d  = res_q;
    bit_d  = bit_q;
    prod_d = prod_q;
    env_d  = env_q;
    last_d = last_q;
    case (state_q)
      EU_IDLE: begin
        if (start_i) begin
          quo_d  = sum_i;
          fr_d   = frames_i;
          ch_d   = ch_i;
          last_d = last_i;
        end
      end
      EU_COUNT: begin
        cnt_d = CntW'(fr_q) * CntW'(ch_q);
        rem_d = '0;
        it_d  = ItW'(SumW);
      end
      EU_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_sh >= {1'b0, cnt_q}) begin
          rem_d = CntW'(rem_sh - {1'b0, cnt_q});
          quo_d = {quo_q[SumW-2:0], 1'b1};
        end else begin
          rem_d = rem_sh[CntW-1:0];
          quo_d = {quo_q[SumW-2:0], 1'b0};
        end
        it_d = it_q - ItW'(1);
        if (it_q == ItW'(1)) begin
          v_d   = quo_d[31:0];
          res_d = '0;
          bit_d = 32'h4000_0000;
        end
      end
      EU_SQRT: begin
        if (v_q >= trial) begin
          v_d   = v_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
      EU_MUL: begin
        if (rms <= noise_floor_i) begin
          prod_d = '0;
        end else begin
          prod_d = 32'(rms - noise_floor_i) * 32'(env_scale_i);
        end
      end
      EU_CLAMP: begin
        env_d = (shifted > 24'(EnvMax)) ? EnvMax : shifted[15:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EU_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    fr_q   <= fr_d;
    ch_q   <= ch_d;
    it_q   <= it_d;
    v_q    <= v_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    prod_q <= prod_d;
    env_q  <= env_d;
    last_q <= last_d;
  end

  assign ready_o     = (state_q == EU_IDLE);
  assign res_valid_o = (state_q == EU_DONE);
  assign res_env_o   = env_q;
  assign res_last_o  = last_q;

`ifndef ASSERT_OFF
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_env_o <= EnvMax)) else $error("envelope above full scale");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && ready_o) |=> (state_q == EU_COUNT)) else $error("start not taken");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_env_o)))
    else $error("result dropped");
`endif

endmodule

// ===== hdl/windowed_rms_envelope.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   16+1   tdata: sample[15:0]; tlast: end_of_clip
// m_axis    out  16+1   tdata: envelope[15:0]; tlast: last_of_clip
// cfg       in   3+16   cfg_index_i selects the register, cfg_data_i holds the value
//
// A sample passes the square state, the update state if it ends a frame, then check.
// Each closing window runs through a shared divide and square root unit, built from
// one-bit-per-cycle loops; it takes no new window until its last result is taken.
// Reset clears the windows, counters and output valid flag; registers take defaults.
// A stalled m_axis holds one result in the output register and one in the unit.
module windowed_rms_envelope import wre_pkg::*; #(
  parameter int unsigned MAX_OPEN     = MaxOpenDef,
  parameter int unsigned MAX_WINDOW   = MaxWindowDef,
  parameter int unsigned MAX_CHANNELS = MaxChannelsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // sample
  input  logic               s_axis_tlast,  // end_of_clip
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // envelope
  output logic               m_axis_tlast,  // last_of_clip
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  localparam int unsigned ChW  = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned FrW  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned OcW  = $clog2(MAX_OPEN + 1);
  localparam int unsigned FsW  = 31 + ChW;
  localparam int unsigned SumW = 31 + ChW + FrW;

  logic [12:0] win_cfg_q, hop_cfg_q;
  logic [3:0]  ch_cfg_q;
  logic [15:0] nf_q, scale_q;

  top_state_e state_q, state_d;

  logic [15:0]     sample_q;
  logic            end_q;
  logic [FsW-1:0]  fsum_q, fsum_d;
  logic [ChW-1:0]  ci_q, ci_d;
  logic [FrW-1:0]  hc_q, hc_d;
  logic [OcW-1:0]  cnt_q, cnt_d;
  logic            fdone_q, fdone_d;
  logic            out_v_q;
  logic [15:0]     out_env_q;
  logic            out_last_q;

  logic [ChW-1:0]  ch_eff;
  logic [FrW-1:0]  hop_eff, win_eff;
  logic [31:0]     hop_lim;
  logic [31:0]     sq;
  logic            frame_done;
  logic [FrW-1:0]  hc_wrap, hc_inc;
  logic            opening;
  logic            close_want, close_go;
  cell_ctl_t       ctl;

  logic [MAX_OPEN-1:0]  c_valid;
  logic [SumW-1:0]      c_sum    [MAX_OPEN];
  logic [FrW-1:0]       c_frames [MAX_OPEN];

  logic            eu_ready, eu_rvalid, eu_rready, eu_rlast;
  logic [15:0]     eu_renv;

  // Effective register values after range limiting.
  always_comb begin
    if (ch_cfg_q == 4'd0) begin
      ch_eff = ChW'(1);
    end else if (32'(ch_cfg_q) > MAX_CHANNELS) begin
      ch_eff = ChW'(MAX_CHANNELS);
    end else begin
      ch_eff = ChW'(ch_cfg_q);
    end
    if (hop_cfg_q == 13'd0) begin
      hop_eff = FrW'(1);
    end else if (32'(hop_cfg_q) > MAX_WINDOW) begin
      hop_eff = FrW'(MAX_WINDOW);
    end else begin
      hop_eff = FrW'(hop_cfg_q);
    end
    if (win_cfg_q == 13'd0) begin
      win_eff = FrW'(1);
    end else if (32'(win_cfg_q) > MAX_WINDOW) begin
      win_eff = FrW'(MAX_WINDOW);
    end else begin
      win_eff = FrW'(win_cfg_q);
    end
    hop_lim = 32'(hop_eff) * 32'(MAX_OPEN);
    if (32'(win_eff) > hop_lim) begin
      win_eff = FrW'(hop_lim);
    end
  end

  always_comb begin
    sq         = 32'($signed(sample_q)) * 32'($signed(sample_q));
    frame_done = (32'(ci_q) + 32'd1) >= 32'(ch_eff);
    hc_wrap    = (hc_q >= hop_eff) ? '0 : hc_q;
    opening    = (hc_wrap == '0) && (32'(cnt_q) < MAX_OPEN);
    hc_inc     = hc_wrap + FrW'(1);
    // Full windows close only once a frame has been taken in.
    close_want = (cnt_q != '0) && ((fdone_q && (c_frames[0] >= win_eff)) || end_q);
    close_go   = close_want && eu_ready;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (s_axis_tvalid) state_d = ST_SQUARE;
      ST_SQUARE: state_d = frame_done ? ST_UPDATE : ST_CHECK;
      ST_UPDATE: state_d = ST_CHECK;
      ST_CHECK:  if (!close_want) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl     = '0;
    fsum_d  = fsum_q;
    ci_d    = ci_q;
    hc_d    = hc_q;
    cnt_d   = cnt_q;
    fdone_d = fdone_q;
    case (state_q)
      ST_SQUARE: begin
        fsum_d  = fsum_q + FsW'(sq);
        ci_d    = frame_done ? '0 : ci_q + ChW'(1);
        fdone_d = frame_done;
      end
      ST_UPDATE: begin
        ctl.add = 1'b1;
        hc_d    = (hc_inc >= hop_eff) ? '0 : hc_inc;
        fsum_d  = '0;
        if (opening) begin
          cnt_d = cnt_q + OcW'(1);
        end
      end
      ST_CHECK: begin
        if (close_go) begin
          ctl.shift = 1'b1;
          cnt_d     = cnt_q - OcW'(1);
        end else if (!close_want && end_q) begin
          // Clip finished: every window is closed, return the clip state to zero.
          ctl.clear = 1'b1;
          fsum_d    = '0;
          ci_d      = '0;
          hc_d      = '0;
          cnt_d     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_cfg_q <= WindowReset;
      hop_cfg_q <= HopReset;
      ch_cfg_q  <= ChReset;
      nf_q      <= '0;
      scale_q   <= ScaleReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegWindowFrames: win_cfg_q <= cfg_data_i[12:0];
        RegHopFrames:    hop_cfg_q <= cfg_data_i[12:0];
        RegChannelCount: ch_cfg_q  <= cfg_data_i[3:0];
        RegNoiseFloor:   nf_q      <= cfg_data_i;
        RegEnvScale:     scale_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fsum_q  <= '0;
      ci_q    <= '0;
      hc_q    <= '0;
      cnt_q   <= '0;
      fdone_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      fsum_q  <= fsum_d;
      ci_q    <= ci_d;
      hc_q    <= hc_d;
      cnt_q   <= cnt_d;
      fdone_q <= fdone_d;
      if (eu_rready) begin
        out_v_q <= eu_rvalid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sample_q <= s_axis_tdata;
      end_q    <= s_axis_tlast;
    end
    if (eu_rready && eu_rvalid) begin
      out_env_q  <= eu_renv;
      out_last_q <= eu_rlast;
    end
  end

  for (genvar g = 0; g < MAX_OPEN; g++) begin : g_cell
    logic            nb_valid;
    logic [SumW-1:0] nb_sum;
    logic [FrW-1:0]  nb_frames;
    if (g == MAX_OPEN - 1) begin : g_tail
      assign nb_valid  = 1'b0;
      assign nb_sum    = '0;
      assign nb_frames = '0;
    end else begin : g_mid
      assign nb_valid  = c_valid[g+1];
      assign nb_sum    = c_sum[g+1];
      assign nb_frames = c_frames[g+1];
    end
    wre_cell #(
      .SumW(SumW),
      .FrW (FrW),
      .FsW (FsW)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .open_i     (opening && (cnt_q == OcW'(g))),
      .frame_sum_i(fsum_q),
      .nb_valid_i (nb_valid),
      .nb_sum_i   (nb_sum),
      .nb_frames_i(nb_frames),
      .valid_o    (c_valid[g]),
      .sum_o      (c_sum[g]),
      .frames_o   (c_frames[g])
    );
  end

  assign eu_rready = !out_v_q || m_axis_tready;

  wre_env #(
    .SumW(SumW),
    .FrW (FrW),
    .ChW (ChW)
  ) u_env (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (close_go && (state_q == ST_CHECK)),
    .sum_i        (c_sum[0]),
    .frames_i     (c_frames[0]),
    .ch_i         (ch_eff),
    .last_i       (end_q && (cnt_q == OcW'(1))),
    .noise_floor_i(nf_q),
    .env_scale_i  (scale_q),
    .ready_o      (eu_ready),
    .res_valid_o  (eu_rvalid),
    .res_ready_i  (eu_rready),
    .res_env_o    (eu_renv),
    .res_last_o   (eu_rlast)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_env_q;
  assign m_axis_tlast  = out_last_q;

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_OPEN) else $error("open window count out of range");
  a_cells_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(c_valid) == 32'(cnt_q)) else $error("cell valid bits disagree with count");
  a_clip_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_CHECK) && end_q && !close_want) |=> (cnt_q == '0))
    else $error("windows left open after end of clip");
`endif

endmodule

// ===== test/wre_checker.sv =====
module wre_checker import wre_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // sample
  input  logic               s_axis_tlast,  // end_of_clip
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [15:0]        m_axis_tdata,  // envelope
  input  logic               m_axis_tlast,  // last_of_clip
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o,
  output int unsigned        samples_o,
  output int unsigned        levels_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] envelope;
    logic        last_of_clip;
  } level_t;

  level_t      level_q[$];

  logic [12:0] win_reg, hop_reg;
  logic [3:0]  chan_reg;
  logic [15:0] floor_reg, scale_reg;

  logic [63:0] win_sum[MaxOpenDef];
  int unsigned win_done[MaxOpenDef];
  int unsigned head, num_open, hop_cnt, chan_idx;
  logic [63:0] frame_acc;

  assign pending_o = level_q.size();

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors_o++;
  endtask

  function automatic logic [63:0] int_root(input logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] level_of(input logic [63:0] sum, input int unsigned frames,
                                           input int unsigned ch);
    logic [63:0] cnt, r, e;
    cnt = 64'(frames) * 64'(ch);
    if (cnt == 0) return 16'd0;
    r = int_root(sum / cnt);
    if (r <= 64'(floor_reg)) return 16'd0;
    e = ((r - 64'(floor_reg)) * 64'(scale_reg)) >> 8;
    if (e > 64'd32768) e = 64'd32768;
    return e[15:0];
  endfunction

  function automatic int unsigned bound(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic close_oldest(input int unsigned ch, inout int n);
    level_t lv;
    lv.envelope     = level_of(win_sum[head], win_done[head], ch);
    lv.last_of_clip = 1'b0;
    level_q.push_back(lv);
    win_sum[head]  = 0;
    win_done[head] = 0;
    head = (head + 1) % MaxOpenDef;
    num_open--;
    n++;
  endtask

  task automatic clear_clip();
    for (int i = 0; i < MaxOpenDef; i++) begin
      win_sum[i]  = 0;
      win_done[i] = 0;
    end
    head = 0;
    num_open = 0;
    hop_cnt = 0;
    chan_idx = 0;
    frame_acc = 0;
  endtask

  task automatic predict_levels(input logic signed [15:0] smp, input logic eoc);
    int unsigned ch, hop, win, slot;
    int n;
    logic signed [31:0] sq;
    ch  = bound(chan_reg, MaxChannelsDef);
    hop = bound(hop_reg, MaxWindowDef);
    win = bound(win_reg, MaxWindowDef);
    n = 0;
    if (win > hop * MaxOpenDef) win = hop * MaxOpenDef;
    sq = 32'(smp) * 32'(smp);
    frame_acc += 64'(unsigned'(sq));
    if (chan_idx + 1 >= ch) begin
      chan_idx = 0;
      if (hop_cnt >= hop) hop_cnt = 0;
      if (hop_cnt == 0 && num_open < MaxOpenDef) begin
        slot = (head + num_open) % MaxOpenDef;
        win_sum[slot]  = 0;
        win_done[slot] = 0;
        num_open++;
      end
      hop_cnt++;
      if (hop_cnt >= hop) hop_cnt = 0;
      for (int k = 0; k < num_open; k++) begin
        slot = (head + k) % MaxOpenDef;
        win_sum[slot] += frame_acc;
        win_done[slot]++;
      end
      frame_acc = 0;
      while (num_open > 0 && win_done[head] >= win) close_oldest(ch, n);
    end else begin
      chan_idx++;
    end
    if (eoc) begin
      while (num_open > 0) close_oldest(ch, n);
      if (n > 0) level_q[level_q.size()-1].last_of_clip = 1'b1;
      clear_clip();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    level_t want;
    if (!rst_ni) begin
      win_reg   = WindowReset;
      hop_reg   = HopReset;
      chan_reg  = ChReset;
      floor_reg = '0;
      scale_reg = ScaleReset;
      errors_o  = 0;
      samples_o = 0;
      levels_o  = 0;
      level_q.delete();
      clear_clip();
    end else begin
      // Blocking updates keep the register values current for a request at the same edge.
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegWindowFrames: win_reg   = cfg_data_i[12:0];
          RegHopFrames:    hop_reg   = cfg_data_i[12:0];
          RegChannelCount: chan_reg  = cfg_data_i[3:0];
          RegNoiseFloor:   floor_reg = cfg_data_i;
          RegEnvScale:     scale_reg = cfg_data_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_levels(s_axis_tdata, s_axis_tlast);
        samples_o++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        levels_o++;
        if (level_q.size() == 0) begin
          report($sformatf("unexpected envelope %0d last %0b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = level_q.pop_front();
          if (m_axis_tdata !== want.envelope)
            report($sformatf("envelope %0d, expected %0d", m_axis_tdata, want.envelope));
          if (m_axis_tlast !== want.last_of_clip)
            report($sformatf("last_of_clip %0b, expected %0b", m_axis_tlast,
                             want.last_of_clip));
        end
      end
    end
  end

endmodule

// ===== test/tb_windowed_rms_envelope.sv =====
module tb_windowed_rms_envelope import wre_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i, rst_ni;
  logic               s_axis_tvalid, s_axis_tready, s_axis_tlast;
  logic [15:0]        s_axis_tdata;   // sample
  logic               m_axis_tvalid, m_axis_tready, m_axis_tlast;
  logic [15:0]        m_axis_tdata;   // envelope
  logic               cfg_valid_i, cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgW-1:0]    cfg_data_i;

  int unsigned errors, pending, samples, levels;
  int unsigned clips, setups;
  bit          quiet;

  windowed_rms_envelope dut (.*);

  wre_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending), .samples_o(samples), .levels_o(levels)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d envelopes outstanding", pending);
    $display("[FAIL] regression broken");
    $finish;
  end

  // The output side stalls in random bursts until the quiet tail of the run.
  initial begin
    m_axis_tready = 1'b1;
    forever begin
      @(posedge clk_i);
      if (!quiet && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CfgW'(val);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic setup(input int unsigned w, input int unsigned h, input int unsigned ch,
                       input int unsigned nf, input int unsigned sc);
    write_reg(RegWindowFrames, w);
    write_reg(RegHopFrames, h);
    write_reg(RegChannelCount, ch);
    write_reg(RegNoiseFloor, nf);
    write_reg(RegEnvScale, sc);
    setups++;
  endtask

  // A frame with no closing window gives no envelope, so allow the block to finish it.
  task automatic wait_idle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_sample(input logic [15:0] smp, input logic eoc);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= eoc;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (eoc) clips++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic pause_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 255)) - 16'd128;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_setup();
    int unsigned w, h, ch, nf, sc;
    w  = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) != 0) ? 0 : 8191)
                                     : $urandom_range(1, 12);
    h  = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    ch = ($urandom_range(0, 9) == 0) ? 15 * $urandom_range(0, 1) : $urandom_range(1, 8);
    case ($urandom_range(0, 3))
      0:       nf = 0;
      1:       nf = $urandom_range(0, 32768);
      default: nf = $urandom_range(0, 3000);
    endcase
    case ($urandom_range(0, 3))
      0:       sc = 256;
      1:       sc = $urandom_range(0, 65535);
      2:       sc = 65535 * $urandom_range(0, 1);
      default: sc = $urandom_range(64, 1024);
    endcase
    setup(w, h, ch, nf, sc);
  endtask

  // A clip is a run of samples closed by end_of_clip; now and then a register is
  // rewritten halfway through while windows are still open.
  task automatic random_clip(input int unsigned len);
    int unsigned mid;
    mid = ($urandom_range(0, 4) == 0) ? len / 2 : 0;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == mid && mid != 0) begin
        pause_input();
        wait_idle();
        case ($urandom_range(0, 3))
          0: write_reg(RegHopFrames, $urandom_range(1, 6));
          1: write_reg(RegWindowFrames, $urandom_range(1, 10));
          2: write_reg(RegNoiseFloor, $urandom_range(0, 4000));
          default: write_reg(RegEnvScale, $urandom_range(0, 65535));
        endcase
      end
      send_sample(random_sample(), i == len - 1);
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = RegWindowFrames;
    cfg_data_i    = '0;
    quiet         = 1'b0;
    clips         = 0;
    setups        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Full-scale and small samples, one window per frame.
    setup(1, 1, 1, 0, 256);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hffff, 1'b1);
    pause_input();
    wait_idle();
    // Largest gain saturates the envelope.
    setup(1, 1, 1, 0, 65535);
    send_sample(16'd100, 1'b0);
    send_sample(16'h8000, 1'b1);
    pause_input();
    wait_idle();
    // A noise floor at full scale hides everything.
    setup(2, 1, 1, 32768, 65535);
    send_sample(16'h7fff, 1'b0);
    send_sample(16'h8000, 1'b1);
    pause_input();
    wait_idle();
    // Registers beyond their range clamp; the clip ends on a partial frame.
    setup(8191, 0, 15, 5, 300);
    for (int i = 0; i < 11; i++) send_sample(random_sample(), i == 10);
    pause_input();
    wait_idle();
    // A clip that ends before its first frame emits nothing.
    setup(4096, 4096, 3, 0, 256);
    send_sample(16'h1234, 1'b1);
    pause_input();
    wait_idle();
    // Huge windows close short at the end of the clip.
    write_reg(RegChannelCount, 1);
    send_sample(16'h4000, 1'b0);
    send_sample(16'hc000, 1'b0);
    send_sample(16'h7fff, 1'b1);
    pause_input();
    wait_idle();

    while (samples < 370) begin
      random_setup();
      repeat ($urandom_range(1, 4)) begin
        if (samples > 320) quiet = 1'b1;
        random_clip($urandom_range(1, 24));
      end
      pause_input();
      wait_idle();
    end

    repeat (200) @(posedge clk_i);
    $display("%0d samples in %0d clips over %0d register setups", samples, clips, setups);
    $display("%0d envelope values checked, %0d mismatches", levels, errors);
    if (errors == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
